>>> hw/rtl/rcmd_pkg.sv
// Shared types, codes and constants for the radio code message deframer.
package rcmd_pkg;

    // Command codes
    localparam logic [1:0] CMD_CODE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // Event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DUP     = 3'd1;
    localparam logic [2:0] EV_START   = 3'd2;
    localparam logic [2:0] EV_DATA    = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;
    localparam logic [2:0] EV_OOS     = 3'd5;
    localparam logic [2:0] EV_TIMEOUT = 3'd6;
    localparam logic [2:0] EV_TICK    = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_SOUND   = 3'd0;
    localparam logic [2:0] CFG_DEDUP   = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_BLINK   = 3'd3;
    localparam logic [2:0] CFG_TONE    = 3'd4;

    localparam logic [15:0] DEDUP_RST   = 16'd200;
    localparam logic [15:0] TIMEOUT_RST = 16'd10000;
    localparam logic [15:0] BLINK_RST   = 16'd100;
    localparam logic [15:0] TONE_RST    = 16'd150;

    localparam logic [7:0] TOP_START = 8'hFF;
    localparam logic [7:0] TOP_END   = 8'hFE;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [6:0] CODE_BITS = 7'd32;

    localparam logic [4:0] TONE_COUNT = 5'd16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] code;
        logic [6:0]  bit_count;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] char_a;
        logic [7:0] char_b;
        logic [7:0] char_c;
        logic [1:0] chars_added;
        logic [7:0] message_length;
        logic       alert_on;
        logic       led_on;
        logic [9:0] tone_hz;
    } result_t;

    // Classified word handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] code;
        logic        valid;
        logic        is_start;
        logic        is_end;
        logic [2:0]  printable;
    } cls_t;

    function automatic logic [9:0] sweep_tone(input logic [3:0] idx);
        logic [9:0] f;
        case (idx)
            4'd0:    f = 10'd200;
            4'd1:    f = 10'd300;
            4'd2:    f = 10'd400;
            4'd3:    f = 10'd500;
            4'd4:    f = 10'd600;
            4'd5:    f = 10'd700;
            4'd6:    f = 10'd800;
            4'd7:    f = 10'd900;
            4'd8:    f = 10'd1000;
            4'd9:    f = 10'd900;
            4'd10:   f = 10'd800;
            4'd11:   f = 10'd700;
            4'd12:   f = 10'd600;
            4'd13:   f = 10'd500;
            4'd14:   f = 10'd400;
            4'd15:   f = 10'd300;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/rcmd_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module rcmd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  rcmd_pkg::item_t     item,
    output logic                word_valid,
    output rcmd_pkg::cls_t      word,
    input  logic                word_take
);

    rcmd_pkg::cls_t cls;
    rcmd_pkg::cls_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push_ok;
    logic [7:0]     ch [3];

    always_comb
    begin
        ch[0] = item.code[23:16];
        ch[1] = item.code[15:8];
        ch[2] = item.code[7:0];
        cls.cmd      = item.cmd;
        cls.code     = item.code;
        cls.valid    = (item.code != 32'd0) && (item.bit_count == rcmd_pkg::CODE_BITS);
        cls.is_start = item.code[31:24] == rcmd_pkg::TOP_START;
        cls.is_end   = item.code[31:24] == rcmd_pkg::TOP_END;
        for (int i = 0; i < 3; i++)
        begin
            cls.printable[2 - i] = (ch[i] >= rcmd_pkg::PRINT_LO)
                                && (ch[i] <= rcmd_pkg::PRINT_HI);
        end
    end

    assign full       = cnt_reg == 2'd2;
    assign push_ok    = push && !full;
    assign word_valid = cnt_reg != 2'd0;
    assign word       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = word_take ? !rd_ptr_reg : rd_ptr_reg;
        case ({push_ok, word_take})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/rcmd_back.sv
// Back end: message, alert and timer state, plus the result queue.
module rcmd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  rcmd_pkg::cls_t      word,
    output logic                word_take,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                pop,
    output logic                empty,
    output rcmd_pkg::result_t   result
);

    // configuration
    logic        sound_reg;
    logic [15:0] dedup_reg;
    logic [15:0] timeout_reg;
    logic [15:0] blink_reg;
    logic [15:0] tone_step_reg;

    // block state
    logic [31:0] clock_reg,       clock_next;
    logic [31:0] last_code_reg,   last_code_next;
    logic [31:0] code_time_reg,   code_time_next;
    logic        receiving_reg,   receiving_next;
    logic [7:0]  expected_reg,    expected_next;
    logic [7:0]  collected_reg,   collected_next;
    logic [31:0] packet_time_reg, packet_time_next;
    logic        alert_reg,       alert_next;
    logic        led_reg,         led_next;
    logic [31:0] blink_time_reg,  blink_time_next;
    logic [3:0]  tone_idx_reg,    tone_idx_next;
    logic [31:0] tone_time_reg,   tone_time_next;
    logic [9:0]  buzzer_reg,      buzzer_next;

    // result queue
    rcmd_pkg::result_t rq_reg [2];
    logic              rq_wr_reg, rq_wr_next;
    logic              rq_rd_reg, rq_rd_next;
    logic [1:0]        rq_cnt_reg, rq_cnt_next;
    logic              pop_ok;

    rcmd_pkg::result_t res;
    logic [2:0]  ev;
    logic [31:0] clk_inc;
    logic [7:0]  room;
    logic [1:0]  n;
    logic [7:0]  ch [3];
    logic [7:0]  src;
    logic [4:0]  idx_inc;

    assign empty     = rq_cnt_reg == 2'd0;
    assign pop_ok    = pop && !empty;
    assign result    = rq_reg[rq_rd_reg];
    assign word_take = word_valid && ((rq_cnt_reg != 2'd2) || pop_ok);

    always_comb
    begin
        clock_next       = clock_reg;
        last_code_next   = last_code_reg;
        code_time_next   = code_time_reg;
        receiving_next   = receiving_reg;
        expected_next    = expected_reg;
        collected_next   = collected_reg;
        packet_time_next = packet_time_reg;
        alert_next       = alert_reg;
        led_next         = led_reg;
        blink_time_next  = blink_time_reg;
        tone_idx_next    = tone_idx_reg;
        tone_time_next   = tone_time_reg;
        buzzer_next      = buzzer_reg;
        ev               = rcmd_pkg::EV_NONE;
        clk_inc          = clock_reg + 32'd1;
        room             = expected_reg - collected_reg;
        n                = 2'd0;
        src              = 8'd0;
        idx_inc          = {1'b0, tone_idx_reg} + 5'd1;
        ch[0]            = 8'd0;
        ch[1]            = 8'd0;
        ch[2]            = 8'd0;

        case (word.cmd)
            rcmd_pkg::CMD_CODE:
            begin
                if ((word.code == last_code_reg)
                    && ((clock_reg - code_time_reg) < {16'd0, dedup_reg}))
                begin
                    ev = rcmd_pkg::EV_DUP;
                end
                else
                begin
                    last_code_next = word.code;
                    code_time_next = clock_reg;
                    if (!word.valid)
                    begin
                        ev = rcmd_pkg::EV_NONE;
                    end
                    else if (word.is_start)
                    begin
                        expected_next    = word.code[7:0];
                        collected_next   = 8'd0;
                        receiving_next   = 1'b1;
                        packet_time_next = clock_reg;
                        ev               = rcmd_pkg::EV_START;
                    end
                    else if (!receiving_reg)
                    begin
                        ev = rcmd_pkg::EV_OOS;
                    end
                    else if (word.is_end)
                    begin
                        alert_next = 1'b1;
                        if (sound_reg)
                        begin
                            tone_idx_next  = 4'd0;
                            tone_time_next = clock_reg;
                        end
                        ev = rcmd_pkg::EV_DONE;
                    end
                    else
                    begin
                        // pack accepted characters to the front, capped at the length
                        for (int i = 0; i < 3; i++)
                        begin
                            src = word.code[23 - 8 * i -: 8];
                            if (word.printable[2 - i] && ({6'd0, n} < room))
                            begin
                                ch[n] = src;
                                n     = n + 2'd1;
                            end
                        end
                        collected_next   = collected_reg + {6'd0, n};
                        packet_time_next = clock_reg;
                        ev               = rcmd_pkg::EV_DATA;
                    end
                end
            end
            rcmd_pkg::CMD_TICK:
            begin
                clock_next = clk_inc;
                if (alert_reg)
                begin
                    if ((clk_inc - blink_time_reg) >= {16'd0, blink_reg})
                    begin
                        led_next        = !led_reg;
                        blink_time_next = clk_inc;
                    end
                    if (sound_reg && ((clk_inc - tone_time_reg) >= {16'd0, tone_step_reg}))
                    begin
                        buzzer_next    = rcmd_pkg::sweep_tone(tone_idx_reg);
                        tone_idx_next  = (idx_inc >= rcmd_pkg::TONE_COUNT) ? 4'd0
                                                                         : idx_inc[3:0];
                        tone_time_next = clk_inc;
                    end
                end
                else
                begin
                    led_next = 1'b0;
                    if (sound_reg)
                    begin
                        buzzer_next = 10'd0;
                    end
                end
                if (receiving_reg && ((clk_inc - packet_time_reg) > {16'd0, timeout_reg}))
                begin
                    receiving_next = 1'b0;
                    expected_next  = 8'd0;
                    collected_next = 8'd0;
                    ev             = rcmd_pkg::EV_TIMEOUT;
                end
                else
                begin
                    ev = rcmd_pkg::EV_TICK;
                end
            end
            rcmd_pkg::CMD_STOP:
            begin
                alert_next  = 1'b0;
                led_next    = 1'b0;
                buzzer_next = 10'd0;
            end
            default:
            begin
                ev = rcmd_pkg::EV_NONE;
            end
        endcase

        res.event_res      = ev;
        res.char_a         = ch[0];
        res.char_b         = ch[1];
        res.char_c         = ch[2];
        res.chars_added    = n;
        res.message_length = collected_next;
        res.alert_on       = alert_next;
        res.led_on         = led_next;
        res.tone_hz        = buzzer_next;

        // length is reported before the finished message is dropped
        if (ev == rcmd_pkg::EV_DONE)
        begin
            receiving_next = 1'b0;
            expected_next  = 8'd0;
            collected_next = 8'd0;
        end
    end

    always_comb
    begin
        rq_wr_next = word_take ? !rq_wr_reg : rq_wr_reg;
        rq_rd_next = pop_ok ? !rq_rd_reg : rq_rd_reg;
        case ({word_take, pop_ok})
            2'b10:   rq_cnt_next = rq_cnt_reg + 2'd1;
            2'b01:   rq_cnt_next = rq_cnt_reg - 2'd1;
            default: rq_cnt_next = rq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            rq_reg[rq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_reg       <= 1'b1;
            dedup_reg       <= rcmd_pkg::DEDUP_RST;
            timeout_reg     <= rcmd_pkg::TIMEOUT_RST;
            blink_reg       <= rcmd_pkg::BLINK_RST;
            tone_step_reg   <= rcmd_pkg::TONE_RST;
            clock_reg       <= 32'd0;
            last_code_reg   <= 32'd0;
            code_time_reg   <= 32'd0;
            receiving_reg   <= 1'b0;
            expected_reg    <= 8'd0;
            collected_reg   <= 8'd0;
            packet_time_reg <= 32'd0;
            alert_reg       <= 1'b0;
            led_reg         <= 1'b0;
            blink_time_reg  <= 32'd0;
            tone_idx_reg    <= 4'd0;
            tone_time_reg   <= 32'd0;
            buzzer_reg      <= 10'd0;
            rq_wr_reg       <= 1'b0;
            rq_rd_reg       <= 1'b0;
            rq_cnt_reg      <= 2'd0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_next;
            rq_rd_reg  <= rq_rd_next;
            rq_cnt_reg <= rq_cnt_next;
            if (word_take)
            begin
                clock_reg       <= clock_next;
                last_code_reg   <= last_code_next;
                code_time_reg   <= code_time_next;
                receiving_reg   <= receiving_next;
                expected_reg    <= expected_next;
                collected_reg   <= collected_next;
                packet_time_reg <= packet_time_next;
                alert_reg       <= alert_next;
                led_reg         <= led_next;
                blink_time_reg  <= blink_time_next;
                tone_idx_reg    <= tone_idx_next;
                tone_time_reg   <= tone_time_next;
                buzzer_reg      <= buzzer_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rcmd_pkg::CFG_SOUND:
                    begin
                        sound_reg <= cfg_data[0];
                        if (!cfg_data[0])
                        begin
                            buzzer_reg <= 10'd0;
                        end
                    end
                    rcmd_pkg::CFG_DEDUP:   dedup_reg     <= cfg_data;
                    rcmd_pkg::CFG_TIMEOUT: timeout_reg   <= cfg_data;
                    rcmd_pkg::CFG_BLINK:   blink_reg     <= cfg_data;
                    rcmd_pkg::CFG_TONE:    tone_step_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/radio_code_message_deframer_core.sv
// Radio code message deframer: top level joining the front end and back end.
//
// Input channel: drive item and raise push; a word is taken on a clock edge
// with push high and full low. Each word is a received code, a 1 ms tick or
// a stop-alert request. Result channel: while empty is low, result holds the
// oldest result word; it is taken on an edge with pop high. Every input word
// gives exactly one result word, in order.
// Configuration: cfg_we with cfg_index and cfg_data writes a register; write
// only while no words are in flight. Index 5..7 is ignored.
// A taken word is held in the front queue, then the back end writes its result
// into the result queue, from which it can be popped. Throughput: one word per
// cycle while the result queue has room or is being popped, set by the back end,
// which updates all message, alert and timer state for each word that it takes.
// Stalls: two-entry queues on both sides; with pop held low the result
// queue fills, the back end stops, and full rises once the front queue fills.
// Reset clears all state and queues and loads the register defaults
// (sound on, 200, 10000, 100, 150 ms); no clearing pass is needed.
module radio_code_message_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  rcmd_pkg::item_t     item,
    output logic                empty,
    input  logic                pop,
    output rcmd_pkg::result_t   result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic           word_valid;
    logic           word_take;
    rcmd_pkg::cls_t word;

    rcmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take)
    );

    rcmd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (word_take),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the radio code message deframer: queued words checked against a local predictor.
module tb_top;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 80;
    localparam int         MAX_PRINT   = 40;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    rcmd_pkg::item_t   item      = '0;
    logic              empty;
    logic              pop       = 1'b0;
    rcmd_pkg::result_t result;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_index = rcmd_pkg::CFG_SOUND;
    logic [15:0]       cfg_data  = '0;

    radio_code_message_deframer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor registers
    logic        snd_en;
    logic [15:0] dedup_ms;
    logic [15:0] tmo_ms;
    logic [15:0] blink_ms;
    logic [15:0] tone_ms;

    // predictor state
    logic [31:0] now_ms;
    logic [31:0] prev_code;
    logic [31:0] prev_code_at;
    logic        rx_active;
    logic [7:0]  rx_len;
    logic [7:0]  rx_count;
    logic [31:0] rx_last_at;
    logic        alert;
    logic        led;
    logic [31:0] blink_at;
    logic [3:0]  tone_idx;
    logic [31:0] tone_at;
    logic [9:0]  buzz_hz;
    logic [9:0]  sweep_hz [16] = '{10'd200, 10'd300, 10'd400, 10'd500, 10'd600, 10'd700,
                                  10'd800, 10'd900, 10'd1000, 10'd900, 10'd800, 10'd700,
                                  10'd600, 10'd500, 10'd400, 10'd300};

    rcmd_pkg::item_t   pending_words[$];
    rcmd_pkg::result_t predicted_results[$];
    int          words_taken     = 0;
    int          words_queued    = 0;
    int          results_checked = 0;
    int          mismatches      = 0;
    int          cycles          = 0;
    int          ev_seen [8]     = '{default: 0};
    int          hold_left       = 0;
    int          holds_done      = 0;
    int          burst_left      = 1;
    int          gap_left        = 0;
    int          stall_left      = 0;
    int          stall_mode      = 0;
    logic [31:0] last_sent       = '0;

    function automatic void predictor_reset();
        snd_en       = 1'b1;
        dedup_ms     = rcmd_pkg::DEDUP_RST;
        tmo_ms       = rcmd_pkg::TIMEOUT_RST;
        blink_ms     = rcmd_pkg::BLINK_RST;
        tone_ms      = rcmd_pkg::TONE_RST;
        now_ms       = '0;
        prev_code    = '0;
        prev_code_at = '0;
        rx_active    = 1'b0;
        rx_len       = '0;
        rx_count     = '0;
        rx_last_at   = '0;
        alert        = 1'b0;
        led          = 1'b0;
        blink_at     = '0;
        tone_idx     = '0;
        tone_at      = '0;
        buzz_hz      = '0;
    endfunction

    function automatic void drop_message();
        rx_active = 1'b0;
        rx_len    = '0;
        rx_count  = '0;
    endfunction

    // one result per word
    function automatic rcmd_pkg::result_t deframe_step(input rcmd_pkg::item_t w);
        rcmd_pkg::result_t r;
        logic [7:0]        ch;
        int                n;
        int                i;
        r = '0;
        r.event_res = rcmd_pkg::EV_NONE;
        case (w.cmd)
            rcmd_pkg::CMD_CODE:
            begin
                if (w.code == prev_code && (now_ms - prev_code_at) < {16'd0, dedup_ms})
                    r.event_res = rcmd_pkg::EV_DUP;
                else
                begin
                    prev_code    = w.code;
                    prev_code_at = now_ms;
                    if (w.code == '0 || w.bit_count != rcmd_pkg::CODE_BITS)
                        r.event_res = rcmd_pkg::EV_NONE;
                    else if (w.code[31:24] == rcmd_pkg::TOP_START)
                    begin
                        rx_len      = w.code[7:0];
                        rx_count    = '0;
                        rx_active   = 1'b1;
                        rx_last_at  = now_ms;
                        r.event_res = rcmd_pkg::EV_START;
                    end
                    else if (w.code[31:24] == rcmd_pkg::TOP_END)
                    begin
                        if (!rx_active)
                            r.event_res = rcmd_pkg::EV_OOS;
                        else
                        begin
                            alert = 1'b1;
                            if (snd_en)
                            begin
                                tone_idx = '0;
                                tone_at  = now_ms;
                            end
                            r.event_res = rcmd_pkg::EV_DONE;
                        end
                    end
                    else if (!rx_active)
                        r.event_res = rcmd_pkg::EV_OOS;
                    else
                    begin
                        n = 0;
                        for (i = 0; i < 3; i++)
                        begin
                            ch = w.code[23 - 8 * i -: 8];
                            if (ch >= rcmd_pkg::PRINT_LO && ch <= rcmd_pkg::PRINT_HI
                                && rx_count < rx_len)
                            begin
                                case (n)
                                    0:       r.char_a = ch;
                                    1:       r.char_b = ch;
                                    default: r.char_c = ch;
                                endcase
                                n++;
                                rx_count = rx_count + 8'd1;
                            end
                        end
                        r.chars_added = n[1:0];
                        rx_last_at    = now_ms;
                        r.event_res   = rcmd_pkg::EV_DATA;
                    end
                end
            end
            rcmd_pkg::CMD_TICK:
            begin
                now_ms = now_ms + 32'd1;
                if (alert)
                begin
                    if (now_ms - blink_at >= {16'd0, blink_ms})
                    begin
                        led      = ~led;
                        blink_at = now_ms;
                    end
                    if (snd_en && now_ms - tone_at >= {16'd0, tone_ms})
                    begin
                        buzz_hz  = sweep_hz[tone_idx];
                        tone_idx = tone_idx + 4'd1;
                        tone_at  = now_ms;
                    end
                end
                else
                begin
                    led = 1'b0;
                    if (snd_en)
                        buzz_hz = '0;
                end
                if (rx_active && now_ms - rx_last_at > {16'd0, tmo_ms})
                begin
                    drop_message();
                    r.event_res = rcmd_pkg::EV_TIMEOUT;
                end
                else
                    r.event_res = rcmd_pkg::EV_TICK;
            end
            rcmd_pkg::CMD_STOP:
            begin
                alert   = 1'b0;
                led     = 1'b0;
                buzz_hz = '0;
            end
            default: ;
        endcase
        r.message_length = rx_count;
        if (r.event_res == rcmd_pkg::EV_DONE)
            drop_message();
        r.alert_on = alert;
        r.led_on   = led;
        r.tone_hz  = buzz_hz;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINT)
            $display("MISMATCH at %0t, result %0d, %s: got %0h, want %0h",
                     $time, results_checked, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk)
    begin
        logic go;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                predicted_results.push_back(deframe_step(pending_words.pop_front()));
                words_taken <= words_taken + 1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else if (!push && gap_left > 0)
                gap_left--;
            go = (gap_left == 0) && (pending_words.size() != 0);
            push <= go;
            if (go)
                item <= pending_words[0];
        end
    end

    // long receiver hold-off so that both queues fill and full rises
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && words_taken >= ((holds_done == 0) ? 150 : 420))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // monitor: compare each popped word with the oldest prediction
    always @(posedge clk)
    begin
        rcmd_pkg::result_t want;
        logic              take;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("word with nothing predicted", 32'(result), '0);
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("event_res", 32'(result.event_res), 32'(want.event_res));
                    check_field("char_a", 32'(result.char_a), 32'(want.char_a));
                    check_field("char_b", 32'(result.char_b), 32'(want.char_b));
                    check_field("char_c", 32'(result.char_c), 32'(want.char_c));
                    check_field("chars_added", 32'(result.chars_added),
                                32'(want.chars_added));
                    check_field("message_length", 32'(result.message_length),
                                32'(want.message_length));
                    check_field("alert_on", 32'(result.alert_on), 32'(want.alert_on));
                    check_field("led_on", 32'(result.led_on), 32'(want.led_on));
                    check_field("tone_hz", 32'(result.tone_hz), 32'(want.tone_hz));
                    ev_seen[want.event_res]++;
                    results_checked++;
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       take = 1'b1;
                1:       take = ($urandom_range(0, 1) == 1);
                2:       take = ($urandom_range(0, 3) == 0);
                default: take = ($urandom_range(0, 9) != 0);
            endcase
            pop <= take && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still predicted",
                     cycles, predicted_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_word(input logic [1:0] c, input logic [31:0] code,
                            input logic [6:0] bits);
        rcmd_pkg::item_t w;
        w.cmd       = c;
        w.code      = code;
        w.bit_count = bits;
        pending_words.push_back(w);
        if (c == rcmd_pkg::CMD_CODE)
            last_sent = code;
        // unused commands and malformed codes do not count toward the total
        if (c != CMD_UNUSED && !(c == rcmd_pkg::CMD_CODE
                                 && (code == '0 || bits != rcmd_pkg::CODE_BITS)))
            words_queued++;
    endtask

    task automatic put_ticks(input int n);
        repeat (n)
            put_word(rcmd_pkg::CMD_TICK, $urandom, 7'($urandom_range(0, 127)));
    endtask

    // data code: any top byte but the framing ones, mostly printable text
    function automatic logic [31:0] text_code();
        logic [31:0] w;
        int          i;
        w[31:24] = 8'($urandom_range(0, 253));
        for (i = 0; i < 3; i++)
            w[8 * i +: 8] = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(32, 126));
        return w;
    endfunction

    task automatic send_traffic(input int count);
        int          stop_at;
        int          k;
        int          len;
        logic [31:0] w32;
        stop_at = words_queued + count;
        while (words_queued < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // well-formed message with random content
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
                w32 = {rcmd_pkg::TOP_START, 16'($urandom), 8'(len)};
                put_word(rcmd_pkg::CMD_CODE, w32, rcmd_pkg::CODE_BITS);
                if ($urandom_range(0, 4) == 0)
                    put_word(rcmd_pkg::CMD_CODE, w32, rcmd_pkg::CODE_BITS);
                k = $urandom_range(0, 4);
                repeat (k)
                begin
                    put_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3));
                    put_word(rcmd_pkg::CMD_CODE, text_code(), rcmd_pkg::CODE_BITS);
                end
                put_ticks($urandom_range(0, 2));
                if ($urandom_range(0, 19) < 17)
                    put_word(rcmd_pkg::CMD_CODE, {rcmd_pkg::TOP_END, 24'($urandom)},
                             rcmd_pkg::CODE_BITS);
                put_ticks($urandom_range(0, 12));
                if ($urandom_range(0, 4) == 0)
                    put_word(rcmd_pkg::CMD_STOP, $urandom, 7'($urandom_range(0, 127)));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       put_word(2'($urandom_range(0, 3)), $urandom,
                                      7'($urandom_range(0, 127)));
                    1:       put_ticks($urandom_range(1, 20));
                    2:       put_word(rcmd_pkg::CMD_CODE, last_sent, rcmd_pkg::CODE_BITS);
                    3:       put_word(rcmd_pkg::CMD_CODE, text_code(),
                                      ($urandom_range(0, 1) == 1) ? rcmd_pkg::CODE_BITS
                                                                  : 7'($urandom_range(0, 127)));
                    default: put_word(rcmd_pkg::CMD_STOP, $urandom,
                                      7'($urandom_range(0, 127)));
                endcase
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            rcmd_pkg::CFG_SOUND:
            begin
                snd_en = val[0];
                if (!val[0])
                    buzz_hz = '0;
            end
            rcmd_pkg::CFG_DEDUP:   dedup_ms = val;
            rcmd_pkg::CFG_TIMEOUT: tmo_ms   = val;
            rcmd_pkg::CFG_BLINK:   blink_ms = val;
            rcmd_pkg::CFG_TONE:    tone_ms  = val;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic snd, input logic [15:0] dedup,
                              input logic [15:0] tmo, input logic [15:0] blink,
                              input logic [15:0] tone);
        cfg_write(rcmd_pkg::CFG_SOUND, {15'd0, snd});
        cfg_write(rcmd_pkg::CFG_DEDUP, dedup);
        cfg_write(rcmd_pkg::CFG_TIMEOUT, tmo);
        cfg_write(rcmd_pkg::CFG_BLINK, blink);
        cfg_write(rcmd_pkg::CFG_TONE, tone);
        cfg_done();
    endtask

    initial
    begin
        predictor_reset();
        // directed words under the reset settings
        put_word(rcmd_pkg::CMD_CODE, 32'h1234_5678, 7'd31);
        put_word(rcmd_pkg::CMD_CODE, 32'h0000_0000, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_CODE, 32'hFE00_0001, rcmd_pkg::CODE_BITS); // end with no start
        put_word(rcmd_pkg::CMD_CODE, 32'h4142_4344, rcmd_pkg::CODE_BITS); // data with no start
        put_word(rcmd_pkg::CMD_TICK, 32'h0, 7'd0);
        put_word(rcmd_pkg::CMD_CODE, 32'hFF00_0006, 7'd64);
        put_word(rcmd_pkg::CMD_CODE, 32'hFF00_0005, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_CODE, 32'hFF00_0005, rcmd_pkg::CODE_BITS); // repeat in window
        put_word(rcmd_pkg::CMD_CODE, 32'h0041_4243, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_CODE, 32'h011F_7E20, rcmd_pkg::CODE_BITS); // fills to the cap
        put_word(rcmd_pkg::CMD_CODE, 32'h0244_4546, rcmd_pkg::CODE_BITS); // capped, none added
        put_word(CMD_UNUSED, 32'hFFFF_FFFF, 7'd127);
        put_word(rcmd_pkg::CMD_STOP, 32'h0, 7'd0);
        put_word(rcmd_pkg::CMD_CODE, 32'hFEFF_FFFF, rcmd_pkg::CODE_BITS);
        put_ticks(3);
        put_word(rcmd_pkg::CMD_CODE, 32'hFFFF_FFFF, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_CODE, 32'h7F7E_7D7C, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_CODE, 32'h00FF_8000, rcmd_pkg::CODE_BITS); // no printable bytes
        put_word(rcmd_pkg::CMD_CODE, 32'hFE00_0000, rcmd_pkg::CODE_BITS);
        put_word(rcmd_pkg::CMD_STOP, 32'hFFFF_FFFF, 7'd127);
        put_word(rcmd_pkg::CMD_TICK, 32'hFFFF_FFFF, 7'd127);
        put_word(rcmd_pkg::CMD_CODE, 32'h0000_0001, rcmd_pkg::CODE_BITS);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        set_config(1'b1, 16'd0, 16'hFFFF, 16'd1, 16'd1);
        send_traffic(110);
        wait_idle();

        set_config(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        send_traffic(100);
        wait_idle();

        set_config(1'b1, 16'd3, 16'd8, 16'd2, 16'd3);
        send_traffic(110);
        wait_idle();

        // zero periods, plus writes to unused indexes that must change nothing
        set_config(1'b1, 16'd200, 16'd30, 16'd0, 16'd0);
        cfg_write(CFG_SPARE_LO, 16'hFFFF);
        cfg_write(CFG_SPARE_HI, 16'h5555);
        cfg_done();
        send_traffic(110);
        wait_idle();

        set_config(1'b1, 16'd10, 16'd50, 16'd5, 16'd2);
        send_traffic(60);
        wait_idle();
        // sound off while the sweep may be playing silences it at once
        cfg_write(rcmd_pkg::CFG_SOUND, 16'd0);
        cfg_done();
        cfg_write(rcmd_pkg::CFG_SOUND, 16'd1);
        cfg_done();
        send_traffic(50);
        wait_idle();

        repeat (10) @(negedge clk);
        $display("Checked %0d result words from %0d input words over six register settings",
                 results_checked, words_taken);
        $display("Events: start %0d data %0d done %0d timeout %0d",
                 ev_seen[rcmd_pkg::EV_START], ev_seen[rcmd_pkg::EV_DATA],
                 ev_seen[rcmd_pkg::EV_DONE], ev_seen[rcmd_pkg::EV_TIMEOUT]);
        $display("        dup %0d oos %0d tick %0d none %0d",
                 ev_seen[rcmd_pkg::EV_DUP], ev_seen[rcmd_pkg::EV_OOS],
                 ev_seen[rcmd_pkg::EV_TICK], ev_seen[rcmd_pkg::EV_NONE]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
